// File: hw/rtl/arp_cache_table_macros.svh
// ----------------------------------------------------------------------------
// ARP cache table assertion macros
// Clocked, reset-qualified wrappers for concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_TABLE_MACROS_SVH
`define ARP_CACHE_TABLE_MACROS_SVH

// same-cycle property
`define ACT_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("arp_cache_table: assertion failed");

// antecedent implies consequent in the next cycle
`define ACT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("arp_cache_table: assertion failed");

`endif

// File: hw/rtl/act_pkg.sv
// ----------------------------------------------------------------------------
// act_pkg
// Shared types, widths and codes of the ARP cache table.
// ----------------------------------------------------------------------------
package act_pkg;

	localparam int DEF_TABLE_ENTRIES    = 16;
	localparam int DEF_MIN_PACKET_BYTES = 28;
	localparam int QUEUE_DEPTH          = 2;

	localparam int PLEN_W   = 11;
	localparam int HTYPE_W  = 16;
	localparam int PROTO_W  = 8;
	localparam int IP_W     = 32;
	localparam int MAC_W    = 48;
	localparam int STATUS_W = 3;

	localparam logic CMD_LEARN  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [HTYPE_W-1:0] HW_TYPE_ETHERNET = 16'd1;
	localparam logic [PROTO_W-1:0] IPV4_ADDR_BYTES  = 8'd4;

	typedef enum logic [STATUS_W-1:0] {
		ST_STORED   = 3'd0,
		ST_SHORT    = 3'd1,
		ST_BAD_TYPE = 3'd2,
		ST_FULL     = 3'd3,
		ST_HIT      = 3'd4,
		ST_MISS     = 3'd5
	} act_status_t;

	typedef enum logic [1:0] {
		OP_SHORT,
		OP_BAD_TYPE,
		OP_LEARN,
		OP_LOOKUP
	} act_op_t;

	typedef struct packed {
		act_op_t          op;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
	} act_item_t;

endpackage

// File: hw/rtl/act_front.sv
// ----------------------------------------------------------------------------
// act_front
// Accepts command transfers, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
module act_front import act_pkg::*; #(
	parameter int MIN_PACKET_BYTES = DEF_MIN_PACKET_BYTES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic               command,
	input  logic [PLEN_W-1:0]  packet_length,
	input  logic [HTYPE_W-1:0] hardware_type,
	input  logic [PROTO_W-1:0] protocol_length,
	input  logic [IP_W-1:0]    ip_address,
	input  logic [MAC_W-1:0]   src_mac,
	output logic               push,
	output act_item_t          push_item,
	input  logic               q_full
);

	logic      slot_vld_q;
	act_item_t slot_item_q;
	act_item_t cls_item;
	logic      accept;

	always_comb begin
		cls_item.ip  = ip_address;
		cls_item.mac = src_mac;
		if (command == CMD_LOOKUP) begin
			cls_item.op = OP_LOOKUP;
		end else if (packet_length < PLEN_W'(MIN_PACKET_BYTES)) begin
			cls_item.op = OP_SHORT;
		end else if (hardware_type != HW_TYPE_ETHERNET ||
		             protocol_length != IPV4_ADDR_BYTES) begin
			cls_item.op = OP_BAD_TYPE;
		end else begin
			cls_item.op = OP_LEARN;
		end
	end

	assign cmd_stall = slot_vld_q && q_full;
	assign accept    = cmd_valid && !cmd_stall;
	assign push      = slot_vld_q && !q_full;
	assign push_item = slot_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= 1'b0;
		end else if (accept) begin
			slot_vld_q <= 1'b1;
		end else if (push) begin
			slot_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_item_q <= cls_item;
		end
	end

endmodule

// File: hw/rtl/act_queue.sv
// ----------------------------------------------------------------------------
// act_queue
// Short FIFO of classified items between front and back end.
// ----------------------------------------------------------------------------
module act_queue import act_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  act_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      pop_vld,
	output act_item_t pop_item
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	act_item_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign pop_vld  = (cnt_q != '0);
	assign pop_item = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && pop_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (do_pop && !do_push) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: hw/rtl/act_back.sv
// ----------------------------------------------------------------------------
// act_back
// Table memory, fill count and scan engine; drives the response register.
// ----------------------------------------------------------------------------
module act_back import act_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_vld,
	input  act_item_t           q_item,
	output logic                q_pop,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [STATUS_W-1:0] status,
	output logic                found,
	output logic [MAC_W-1:0]    mac_address
);

	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESP
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] scan_q;
	logic [IP_W-1:0]  key_q;
	logic             rsp_valid_q;
	act_status_t      rsp_status_q;
	logic             rsp_found_q;
	logic [MAC_W-1:0] rsp_mac_q;
	act_status_t      res_status_q;
	logic             res_found_q;
	logic [MAC_W-1:0] res_mac_q;
	logic             rd_vld_s1;
	logic             rd_last_s1;
	logic [IP_W-1:0]  rd_ip_s1;
	logic [MAC_W-1:0] rd_mac_s1;

	logic [IP_W-1:0]  mem_ip  [TABLE_ENTRIES];
	logic [MAC_W-1:0] mem_mac [TABLE_ENTRIES];

	logic out_free;
	logic table_full;
	logic wr_en;
	logic rd_issue;
	logic rsp_load;

	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign table_full = (fill_q == CNT_W'(TABLE_ENTRIES));
	assign rd_issue   = (state_q == S_SCAN) && (scan_q != fill_q);
	assign wr_en      = q_pop && (q_item.op == OP_LEARN) && !table_full;
	assign rsp_load   = (state_q == S_IDLE && q_pop &&
	                     (q_item.op != OP_LOOKUP || fill_q == '0)) ||
	                    (state_q == S_RESP && out_free);

	always_comb begin
		q_pop = 1'b0;
		if (state_q == S_IDLE && q_vld) begin
			if (q_item.op == OP_LOOKUP && fill_q != '0) begin
				q_pop = 1'b1;
			end else begin
				q_pop = out_free;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_ip[fill_q[IDX_W-1:0]]  <= q_item.ip;
			mem_mac[fill_q[IDX_W-1:0]] <= q_item.mac;
		end
		if (rd_issue) begin
			rd_ip_s1  <= mem_ip[scan_q[IDX_W-1:0]];
			rd_mac_s1 <= mem_mac[scan_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			scan_q       <= '0;
			key_q        <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_MISS;
			rsp_found_q  <= 1'b0;
			rsp_mac_q    <= '0;
			res_status_q <= ST_MISS;
			res_found_q  <= 1'b0;
			res_mac_q    <= '0;
			rd_vld_s1    <= 1'b0;
			rd_last_s1   <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			rd_vld_s1  <= rd_issue;
			rd_last_s1 <= (CNT_W'(scan_q + 1'b1) == fill_q);
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						case (q_item.op)
							OP_SHORT: begin
								rsp_status_q <= ST_SHORT;
								rsp_found_q  <= 1'b0;
								rsp_mac_q    <= '0;
							end
							OP_BAD_TYPE: begin
								rsp_status_q <= ST_BAD_TYPE;
								rsp_found_q  <= 1'b0;
								rsp_mac_q    <= '0;
							end
							OP_LEARN: begin
								rsp_status_q <= table_full ? ST_FULL : ST_STORED;
								rsp_found_q  <= 1'b0;
								rsp_mac_q    <= '0;
								if (!table_full) begin
									fill_q <= CNT_W'(fill_q + 1'b1);
								end
							end
							OP_LOOKUP: begin
								if (fill_q == '0) begin
									rsp_status_q <= ST_MISS;
									rsp_found_q  <= 1'b0;
									rsp_mac_q    <= '0;
								end else begin
									key_q   <= q_item.ip;
									scan_q  <= '0;
									state_q <= S_SCAN;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (rd_issue) begin
						scan_q <= CNT_W'(scan_q + 1'b1);
					end
					if (rd_vld_s1) begin
						if (rd_ip_s1 == key_q) begin
							res_status_q <= ST_HIT;
							res_found_q  <= 1'b1;
							res_mac_q    <= rd_mac_s1;
							state_q      <= S_RESP;
						end else if (rd_last_s1) begin
							res_status_q <= ST_MISS;
							res_found_q  <= 1'b0;
							res_mac_q    <= '0;
							state_q      <= S_RESP;
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						rsp_status_q <= res_status_q;
						rsp_found_q  <= res_found_q;
						rsp_mac_q    <= res_mac_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_status_q;
	assign found       = rsp_found_q;
	assign mac_address = rsp_mac_q;

endmodule

// File: hw/rtl/arp_cache_table.sv
// ----------------------------------------------------------------------------
// arp_cache_table
// Fixed table of IP-to-MAC pairs with learn and lookup commands.
// ----------------------------------------------------------------------------
// Command channel (cmd_valid/cmd_stall): command 0 learns the sender pair of
// a received ARP packet, command 1 looks up ip_address. Response channel
// (rsp_valid/rsp_stall) returns exactly one transfer per command, in order:
// status, found and mac_address.
// A learn or rejected command passes through the front slot, a queue entry
// and the response register before it can be taken from the response channel.
// For a lookup the back end reads the filled entries of the table memory one
// entry per cycle and stops at the first match. Entries fill from index 0
// upward and are never removed, so a fill count stands in for per-entry valid
// bits. The back end takes one learn per cycle while the response is not
// stalled; a lookup holds it until its response is loaded. The front slot
// and a two-entry queue take up to three further commands while the back end
// works or the response waits. Reset empties the table, the queue and the
// response register. While rsp_stall is high the response holds; the back
// end then stops, the queue fills and cmd_stall rises.
// ----------------------------------------------------------------------------
module arp_cache_table import act_pkg::*; #(
	parameter int TABLE_ENTRIES    = DEF_TABLE_ENTRIES,
	parameter int MIN_PACKET_BYTES = DEF_MIN_PACKET_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  logic                command,
	input  logic [PLEN_W-1:0]   packet_length,
	input  logic [HTYPE_W-1:0]  hardware_type,
	input  logic [PROTO_W-1:0]  protocol_length,
	input  logic [IP_W-1:0]     ip_address,
	input  logic [MAC_W-1:0]    src_mac,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [STATUS_W-1:0] status,
	output logic                found,
	output logic [MAC_W-1:0]    mac_address
);

	logic      push;
	act_item_t push_item;
	logic      q_full;
	logic      q_pop;
	logic      q_vld;
	act_item_t q_item;

	act_front #(
		.MIN_PACKET_BYTES(MIN_PACKET_BYTES)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_stall       (cmd_stall),
		.command         (command),
		.packet_length   (packet_length),
		.hardware_type   (hardware_type),
		.protocol_length (protocol_length),
		.ip_address      (ip_address),
		.src_mac         (src_mac),
		.push            (push),
		.push_item       (push_item),
		.q_full          (q_full)
	);

	act_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_vld   (q_vld),
		.pop_item  (q_item)
	);

	act_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_vld       (q_vld),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.found       (found),
		.mac_address (mac_address)
	);

endmodule

// File: hw/rtl/arp_cache_table_chk.sv
// ----------------------------------------------------------------------------
// arp_cache_table_chk
// Port-level checks of the ARP cache table response channel.
// ----------------------------------------------------------------------------
`include "arp_cache_table_macros.svh"

module arp_cache_table_chk import act_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input logic [STATUS_W-1:0] status,
	input logic                found,
	input logic [MAC_W-1:0]    mac_address
);

	logic                      rsp_held;
	logic [STATUS_W+MAC_W:0]   rsp_payload;

	assign rsp_held    = rsp_valid && rsp_stall;
	assign rsp_payload = {status, found, mac_address};

	`ACT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_held, rsp_valid && $stable(rsp_payload))
	`ACT_ASSERT(a_found_is_hit, clk, arst_n, rsp_valid |-> (found == (status == ST_HIT)))
	`ACT_ASSERT(a_mac_zero_on_miss, clk, arst_n, (rsp_valid && !found) |-> (mac_address == '0))
	`ACT_ASSERT(a_status_legal, clk, arst_n, rsp_valid |-> (status <= ST_MISS))

endmodule

bind arp_cache_table arp_cache_table_chk u_chk (.*);

// File: test/tb_arp_cache_table.sv
// ----------------------------------------------------------------------------
// tb_arp_cache_table
// Self-checking testbench for the ARP cache table.
// A short directed run covers the empty-table miss, every learn rejection
// in check order and the length boundary. It also covers stores at the
// field extremes, duplicate IPs and hits and misses. A random run follows:
// mostly lookups of learned IPs, with well-formed learns that slowly fill
// the table and rejected learns mixed in. A scoreboard keeps its own copy
// of the table, predicts one response per accepted command and checks
// responses in order. Both channels idle at random, and the response side
// is once held off long enough to back the command channel up.
// ----------------------------------------------------------------------------
import act_pkg::*;

class arp_table_board;

	typedef struct {
		act_status_t      status;
		logic             found;
		logic [MAC_W-1:0] mac;
	} reply_t;

	bit               valid_of[DEF_TABLE_ENTRIES];
	logic [IP_W-1:0]  ip_of[DEF_TABLE_ENTRIES];
	logic [MAC_W-1:0] mac_of[DEF_TABLE_ENTRIES];
	reply_t           expected_replies[$];
	int               errors;

	function new();
		errors = 0;
		foreach (valid_of[k]) valid_of[k] = 1'b0;
	endfunction

	function void note_command(logic cmd, logic [PLEN_W-1:0] plen,
			logic [HTYPE_W-1:0] htype, logic [PROTO_W-1:0] proto,
			logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
		reply_t r;
		r.status = ST_MISS;
		r.found  = 1'b0;
		r.mac    = '0;
		if (cmd == CMD_LEARN) begin
			if (plen < DEF_MIN_PACKET_BYTES) begin
				r.status = ST_SHORT;
			end else if (htype != HW_TYPE_ETHERNET || proto != IPV4_ADDR_BYTES) begin
				r.status = ST_BAD_TYPE;
			end else begin
				r.status = ST_FULL;
				for (int k = 0; k < DEF_TABLE_ENTRIES; k++) begin
					if (!valid_of[k]) begin
						valid_of[k] = 1'b1;
						ip_of[k]    = ip;
						mac_of[k]   = mac;
						r.status    = ST_STORED;
						break;
					end
				end
			end
		end else begin
			for (int k = 0; k < DEF_TABLE_ENTRIES; k++) begin
				if (valid_of[k] && ip_of[k] == ip) begin
					r.status = ST_HIT;
					r.found  = 1'b1;
					r.mac    = mac_of[k];
					break;
				end
			end
		end
		expected_replies.push_back(r);
	endfunction

	function void check_response(logic [STATUS_W-1:0] st, logic f, logic [MAC_W-1:0] m);
		reply_t r;
		if (expected_replies.size() == 0) begin
			$error("response transfer with no command outstanding: status %0d", st);
			errors++;
			return;
		end
		r = expected_replies.pop_front();
		if (st !== r.status) begin
			$error("status: expected %0d, actual %0d", r.status, st);
			errors++;
		end
		if (f !== r.found) begin
			$error("found: expected %0d, actual %0d", r.found, f);
			errors++;
		end
		if (m !== r.mac) begin
			$error("mac_address: expected %h, actual %h", r.mac, m);
			errors++;
		end
	endfunction

	function int pending();
		return expected_replies.size();
	endfunction

endclass

module tb_arp_cache_table;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 780;
	localparam int HOLD_CYCLES  = 80;
	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 40;

	logic                clk             = 1'b0;
	logic                arst_n          = 1'b0;
	logic                cmd_valid       = 1'b0;
	logic                cmd_stall;
	logic                command         = CMD_LEARN;
	logic [PLEN_W-1:0]   packet_length   = '0;
	logic [HTYPE_W-1:0]  hardware_type   = '0;
	logic [PROTO_W-1:0]  protocol_length = '0;
	logic [IP_W-1:0]     ip_address      = '0;
	logic [MAC_W-1:0]    src_mac         = '0;
	logic                rsp_valid;
	logic                rsp_stall       = 1'b0;
	logic [STATUS_W-1:0] status;
	logic                found;
	logic [MAC_W-1:0]    mac_address;

	arp_table_board  board = new();
	logic [IP_W-1:0] known_ips[$];
	bit              idle_on      = 1'b1;
	bit              hold_request = 1'b0;
	bit              holding      = 1'b0;

	arp_cache_table #(
		.TABLE_ENTRIES    (DEF_TABLE_ENTRIES),
		.MIN_PACKET_BYTES (DEF_MIN_PACKET_BYTES)
	) DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_stall       (cmd_stall),
		.command         (command),
		.packet_length   (packet_length),
		.hardware_type   (hardware_type),
		.protocol_length (protocol_length),
		.ip_address      (ip_address),
		.src_mac         (src_mac),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.status          (status),
		.found           (found),
		.mac_address     (mac_address)
	);

	always #5 clk = ~clk;

	task automatic send_command(logic cmd, logic [PLEN_W-1:0] plen,
			logic [HTYPE_W-1:0] htype, logic [PROTO_W-1:0] proto,
			logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
		if (idle_on && !hold_request && !holding && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_valid       <= 1'b1;
		command         <= cmd;
		packet_length   <= plen;
		hardware_type   <= htype;
		protocol_length <= proto;
		ip_address      <= ip;
		src_mac         <= mac;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		board.note_command(cmd, plen, htype, proto, ip, mac);
	endtask

	task automatic wait_for_drain();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	// response side: checks and stall bursts
	initial begin
		int stall_left;
		stall_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall)
				board.check_response(status, found, mac_address);
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if (hold_request) begin
				hold_request = 1'b0;
				holding      = 1'b1;
				stall_left   = HOLD_CYCLES - 1;
				rsp_stall <= 1'b1;
			end else begin
				holding = 1'b0;
				if (idle_on && $urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(1, 4) - 1;
					rsp_stall <= 1'b1;
				end else begin
					rsp_stall <= 1'b0;
				end
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int               pick;
		logic             cmd;
		logic [PLEN_W-1:0]  plen;
		logic [HTYPE_W-1:0] htype;
		logic [PROTO_W-1:0] proto;
		logic [IP_W-1:0]    ip;
		logic [MAC_W-1:0]   mac;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, rejections in check order, length boundary
		send_command(CMD_LOOKUP, '0, '0, '0, 32'h0, '0);
		send_command(CMD_LOOKUP, '1, '1, '1, 32'hFFFF_FFFF, '1);
		send_command(CMD_LEARN, 11'd0, HW_TYPE_ETHERNET, IPV4_ADDR_BYTES, 32'h0A00_0001,
			48'h1);
		send_command(CMD_LEARN, 11'd27, HW_TYPE_ETHERNET, IPV4_ADDR_BYTES, 32'h0A00_0002,
			48'h2);
		send_command(CMD_LEARN, 11'd27, 16'h0, 8'h0, 32'h0A00_0003, 48'h3);
		send_command(CMD_LEARN, 11'd28, 16'h0, IPV4_ADDR_BYTES, 32'h0A00_0004, 48'h4);
		send_command(CMD_LEARN, 11'd28, 16'hFFFF, IPV4_ADDR_BYTES, 32'h0A00_0005, 48'h5);
		send_command(CMD_LEARN, 11'd28, HW_TYPE_ETHERNET, 8'h0, 32'h0A00_0006, 48'h6);
		send_command(CMD_LEARN, 11'd28, HW_TYPE_ETHERNET, 8'hFF, 32'h0A00_0007, 48'h7);
		send_command(CMD_LEARN, 11'd2047, 16'h0100, IPV4_ADDR_BYTES, 32'h0A00_0008, 48'h8);
		// stores at the extremes, then a duplicate IP
		send_command(CMD_LEARN, 11'd28, HW_TYPE_ETHERNET, IPV4_ADDR_BYTES, 32'h0, 48'h0);
		send_command(CMD_LEARN, 11'd2047, HW_TYPE_ETHERNET, IPV4_ADDR_BYTES, 32'hFFFF_FFFF,
			48'hFFFF_FFFF_FFFF);
		send_command(CMD_LEARN, 11'd60, HW_TYPE_ETHERNET, IPV4_ADDR_BYTES, 32'hC0A8_0001,
			48'h0011_2233_4455);
		send_command(CMD_LEARN, 11'd60, HW_TYPE_ETHERNET, IPV4_ADDR_BYTES, 32'hC0A8_0001,
			48'hAABB_CCDD_EEFF);
		known_ips.push_back(32'h0);
		known_ips.push_back(32'hFFFF_FFFF);
		known_ips.push_back(32'hC0A8_0001);
		send_command(CMD_LOOKUP, '1, '1, '1, 32'hC0A8_0001, '1);
		send_command(CMD_LOOKUP, '0, '0, '0, 32'h0, '0);
		send_command(CMD_LOOKUP, '0, '0, '0, 32'hFFFF_FFFF, '0);
		send_command(CMD_LOOKUP, 11'd28, HW_TYPE_ETHERNET, IPV4_ADDR_BYTES, 32'hC0A8_0002,
			48'h0011_2233_4455);
		send_command(CMD_LOOKUP, '0, '0, '0, 32'h0A00_0004, '0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			idle_on = (n < RANDOM_ITEMS - 100) && ((n % 200) < 160);
			if (n == 150)
				hold_request = 1'b1;
			if (n == 400)
				wait_for_drain();
			pick  = $urandom_range(0, 99);
			plen  = 11'($urandom_range(0, 2047));
			htype = 16'($urandom);
			proto = 8'($urandom);
			mac   = {16'($urandom), 32'($urandom)};
			ip    = $urandom;
			if (pick < 6) begin
				cmd   = CMD_LEARN;
				htype = HW_TYPE_ETHERNET;
				proto = IPV4_ADDR_BYTES;
				plen  = $urandom_range(0, 1) ? 11'($urandom_range(28, 64)) : plen;
				if (plen < DEF_MIN_PACKET_BYTES)
					plen = 11'(DEF_MIN_PACKET_BYTES);
				if ($urandom_range(0, 3) == 0)
					ip = known_ips[$urandom_range(0, known_ips.size() - 1)];
				known_ips.push_back(ip);
			end else if (pick < 20) begin
				cmd = CMD_LEARN;
				case ($urandom_range(0, 3))
					0: begin
						plen = 11'($urandom_range(0, DEF_MIN_PACKET_BYTES - 1));
						htype = HW_TYPE_ETHERNET;
						proto = IPV4_ADDR_BYTES;
					end
					1: proto = IPV4_ADDR_BYTES;
					2: htype = HW_TYPE_ETHERNET;
					default: ;
				endcase
			end else begin
				cmd = CMD_LOOKUP;
				if (pick < 75)
					ip = known_ips[$urandom_range(0, known_ips.size() - 1)];
				else if (pick < 85)
					ip = known_ips[$urandom_range(0, known_ips.size() - 1)]
						^ (32'h1 << $urandom_range(0, 31));
			end
			send_command(cmd, plen, htype, proto, ip, mac);
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
